// File: hdl/dsteer_pkg.sv
// Shared types, constants and the exp(-2^(k-14)) table for the steering predictor.
// No dependencies.
package dsteer_pkg;

  localparam int STAMP_W = 48;
  localparam int ANGLE_W = 16;
  localparam int TAU_W   = 24;
  localparam int DEAD_W  = 20;
  localparam int ACC_W   = 48;
  localparam int PROD_W  = 42;
  localparam int E_W     = 25;

  localparam logic [24:0] ONE_Q24  = 25'd16777216;
  localparam logic [48:0] HALF_Q24 = 49'd8388608;
  localparam logic [47:0] KEEP_US  = 48'd300000;

  // register byte addresses
  localparam logic [2:0] REG_TAU  = 3'd0;
  localparam logic [2:0] REG_DEAD = 3'd4;

  typedef enum logic [2:0] {
    DEC_IDLE, DEC_CHK, DEC_DIV, DEC_EXP, DEC_DONE
  } dec_state_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ST_WR, S_ST_CHK, S_DEC_WAIT, S_ADD, S_SA_RD, S_SA_CHK,
    S_SB_RD, S_SB_CAP, S_SB_EVAL, S_FIN
  } st_e;

  typedef enum logic [1:0] {
    CTX_PRED, CTX_MID, CTX_LAST
  } ctx_e;

  // exp(-2^(k-14)) in Q0.24
  function automatic logic [23:0] decay_factor(input logic [4:0] k);
    logic [23:0] f;
    case (k)
      5'd0:    f = 24'd16776192;
      5'd1:    f = 24'd16775168;
      5'd2:    f = 24'd16773120;
      5'd3:    f = 24'd16769026;
      5'd4:    f = 24'd16760840;
      5'd5:    f = 24'd16744480;
      5'd6:    f = 24'd16711808;
      5'd7:    f = 24'd16646655;
      5'd8:    f = 24'd16517109;
      5'd9:    f = 24'd16261035;
      5'd10:   f = 24'd15760736;
      5'd11:   f = 24'd14805841;
      5'd12:   f = 24'd13066109;
      5'd13:   f = 24'd10175896;
      5'd14:   f = 24'd6171993;
      5'd15:   f = 24'd2270549;
      5'd16:   f = 24'd307285;
      5'd17:   f = 24'd5628;
      default: f = 24'd0;
    endcase
    return f;
  endfunction

endpackage

// File: hdl/dsteer_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dsteer_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: hdl/dsteer_decay.sv
// Decay unit: exp(-(to-from)/tau) in Q1.24 via a bit-serial divider and a
// serial product over table factors. Depends on dsteer_pkg.
module dsteer_decay import dsteer_pkg::*; #(
  parameter int EXP_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [STAMP_W-1:0] from_i,
  input  logic [STAMP_W-1:0] to_i,
  input  logic [TAU_W-1:0]   tau_i,
  output logic               done_o,
  output logic [E_W-1:0]     e_o
);

  localparam int Q  = EXP_TABLE_BITS + 4;
  localparam int JW = $clog2(Q);

  dec_state_e       st_q, st_d;
  logic [STAMP_W-1:0] d_q, d_d;
  logic [TAU_W-1:0] rem_q, rem_d;
  logic [Q-1:0]     q_q, q_d;
  logic [JW-1:0]    j_q, j_d;
  logic [E_W-1:0]   e_q, e_d;

  logic [TAU_W-1:0] tau_eff;
  logic             nb;
  logic [1:0]       nb_idx;
  logic [TAU_W:0]   rem2;
  logic [4:0]       fk;
  logic [48:0]      prod;
  logic [48:0]      rnd;

  always_comb begin
    tau_eff = (tau_i == '0) ? TAU_W'(1) : tau_i;
    nb_idx  = 2'(32'(j_q) - EXP_TABLE_BITS);
    nb      = (32'(j_q) >= EXP_TABLE_BITS) ? d_q[nb_idx] : 1'b0;
    rem2    = {rem_q, nb};
    fk      = 5'(32'(j_q) + 14 - EXP_TABLE_BITS);
    prod    = 49'(e_q) * 49'(decay_factor(fk));
    rnd     = prod + HALF_Q24;
  end

  always_comb begin
    st_d  = st_q;
    d_d   = d_q;
    rem_d = rem_q;
    q_d   = q_q;
    j_d   = j_q;
    e_d   = e_q;
    case (st_q)
      DEC_IDLE: begin
        if (start_i) begin
          d_d  = (to_i > from_i) ? to_i - from_i : '0;
          st_d = DEC_CHK;
        end
      end
      DEC_CHK: begin
        // quotient would reach 2^Q: factor is zero
        if (d_q[STAMP_W-1:4] >= (STAMP_W-4)'(tau_eff)) begin
          e_d  = '0;
          st_d = DEC_DONE;
        end else begin
          rem_d = d_q[TAU_W+3:4];
          q_d   = '0;
          j_d   = JW'(Q - 1);
          st_d  = DEC_DIV;
        end
      end
      DEC_DIV: begin
        if (rem2 >= {1'b0, tau_eff}) begin
          rem_d  = TAU_W'(rem2 - {1'b0, tau_eff});
          q_d[j_q] = 1'b1;
        end else begin
          rem_d = rem2[TAU_W-1:0];
        end
        if (j_q == '0) begin
          e_d  = ONE_Q24;
          st_d = DEC_EXP;
        end else begin
          j_d = j_q - 1'b1;
        end
      end
      DEC_EXP: begin
        if (q_q[j_q]) begin
          e_d = rnd[48:24];
        end
        if (j_q == JW'(Q - 1)) begin
          st_d = DEC_DONE;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      DEC_DONE: st_d = DEC_IDLE;
      default:  st_d = DEC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= DEC_IDLE;
      d_q   <= '0;
      rem_q <= '0;
      q_q   <= '0;
      j_q   <= '0;
      e_q   <= '0;
    end else begin
      st_q  <= st_d;
      d_q   <= d_d;
      rem_q <= rem_d;
      q_q   <= q_d;
      j_q   <= j_d;
      e_q   <= e_d;
    end
  end

  assign done_o = (st_q == DEC_DONE);
  assign e_o    = e_q;

endmodule

// File: hdl/delayed_first_order_steer_predictor.sv
// Top level of the steering predictor: command ring in RAM, sequencer, output register.
// Depends on dsteer_pkg, dsteer_ram and dsteer_decay.
//
// Input channel (in_valid_i / in_stall_o) carries cmd_i, now_time_us_i, steer_angle_i.
// cmd_i = 0 stores a command stamped now + dead time; no result is produced.
// cmd_i = 1 computes a prediction and returns one transfer on the output channel
// (out_valid_o / out_stall_i, predicted_angle_o).
// One item is processed at a time; in_stall_o is high while an item is in work.
// A store writes the ring, then checks entry one for a stale drop when the ring holds
// three or more. A predict runs the decay unit once for the held prediction and, when
// more than two commands are held, once per command segment crossed; each run is a
// bit-serial divide, then one table product per quotient bit, before the accumulate.
// The scan reads the ring one entry at a time, for up to 33 runs at depth 32.
// The result sits in an output register; new items are taken while it waits.
// A predict finishing while the previous result is still stalled waits for it.
// Reset empties the ring (count and oldest index cleared), zeroes the last
// prediction and its time, and loads the register defaults; no clearing pass.
// Registers over APB: 0x0 time constant (us), 0x4 dead time (us).
module delayed_first_order_steer_predictor import dsteer_pkg::*; #(
  parameter int BUFFER_DEPTH   = 32,
  parameter int EXP_TABLE_BITS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      cmd_i,
  input  logic [STAMP_W-1:0]        now_time_us_i,
  input  logic signed [ANGLE_W-1:0] steer_angle_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [ANGLE_W-1:0] predicted_angle_o
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int MW = STAMP_W + ANGLE_W;

  st_e  st_q, st_d;
  ctx_e ctx_q, ctx_d;
  logic [TAU_W-1:0]  tau_q;
  logic [DEAD_W-1:0] dead_q;
  logic [CW-1:0]     cnt_q, cnt_d, idx_q, idx_d;
  logic [AW-1:0]     old_q, old_d;
  logic [STAMP_W-1:0] last_t_q, last_t_d, now_q, now_d, stamp_q, stamp_d;
  logic [STAMP_W-1:0] tcur_q, tcur_d, cur_stamp_q, cur_stamp_d;
  logic [STAMP_W-1:0] dfrom_q, dfrom_d, dto_q, dto_d;
  logic signed [ANGLE_W-1:0] last_p_q, last_p_d, ang_q, ang_d;
  logic signed [ANGLE_W-1:0] cur_ang_q, cur_ang_d, prev_ang_q, prev_ang_d;
  logic signed [ANGLE_W-1:0] pred_q, pred_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic dstart_q, dstart_d, out_valid_q, out_valid_d;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [MW-1:0]    mem_wdata, mem_rdata;
  logic             dec_done;
  logic [E_W-1:0]   dec_e;

  logic                 full;
  logic [AW-1:0]        old_n;
  logic [CW-1:0]        cnt_n;
  logic [STAMP_W:0]     stamp_sum;
  logic [STAMP_W-1:0]   stamp_new, rd_stamp;
  logic signed [ANGLE_W-1:0] rd_ang;
  logic signed [E_W:0]       mul_a;
  logic signed [ANGLE_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [ACC_W-1:0]     mag, rsum;
  logic [23:0]          rr;
  logic signed [ANGLE_W-1:0] rs;
  logic                 in_xfer;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [AW:0] s;
    s = (AW+1)'(base) + (AW+1)'(off);
    if (s >= (AW+1)'(BUFFER_DEPTH)) s = s - (AW+1)'(BUFFER_DEPTH);
    return s[AW-1:0];
  endfunction

  dsteer_ram #(.WIDTH(MW), .DEPTH(BUFFER_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dsteer_decay #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_decay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart_q),
    .from_i  (dfrom_q),
    .to_i    (dto_q),
    .tau_i   (tau_q),
    .done_o  (dec_done),
    .e_o     (dec_e)
  );

  // config port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(dead_q) : 32'(tau_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_q  <= TAU_W'(270000);
      dead_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        dead_q <= pwdata[DEAD_W-1:0];
      end else begin
        tau_q <= pwdata[TAU_W-1:0];
      end
    end
  end

  assign in_stall_o = (st_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign rd_stamp   = mem_rdata[MW-1:ANGLE_W];
  assign rd_ang     = $signed(mem_rdata[ANGLE_W-1:0]);

  always_comb begin
    full      = (cnt_q == CW'(BUFFER_DEPTH));
    old_n     = full ? slot(old_q, CW'(1)) : old_q;
    cnt_n     = full ? cnt_q - 1'b1 : cnt_q;
    stamp_sum = (STAMP_W+1)'(now_q) + (STAMP_W+1)'(dead_q);
    stamp_new = stamp_sum[STAMP_W] ? '1 : stamp_sum[STAMP_W-1:0];
    // term multiplier operands: 26-bit factor by 16-bit angle
    if (ctx_q == CTX_PRED) begin
      mul_a = $signed({1'b0, dec_e});
      mul_b = last_p_q;
    end else begin
      mul_a = $signed({1'b0, E_W'(ONE_Q24 - dec_e)});
      mul_b = prev_ang_q;
    end
    mul_p = mul_a * mul_b;
    // round half away from zero, saturate
    mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    rsum = mag + ACC_W'(HALF_Q24);
    rr   = rsum[ACC_W-1:24];
    if (!acc_q[ACC_W-1]) begin
      rs = (rr > 24'd32767) ? 16'sd32767 : $signed(rr[15:0]);
    end else begin
      rs = (rr > 24'd32768) ? -16'sd32768 : $signed(-rr[15:0]);
    end
  end

  always_comb begin
    st_d        = st_q;
    ctx_d       = ctx_q;
    cnt_d       = cnt_q;
    old_d       = old_q;
    idx_d       = idx_q;
    last_t_d    = last_t_q;
    now_d       = now_q;
    stamp_d     = stamp_q;
    tcur_d      = tcur_q;
    cur_stamp_d = cur_stamp_q;
    dfrom_d     = dfrom_q;
    dto_d       = dto_q;
    last_p_d    = last_p_q;
    ang_d       = ang_q;
    cur_ang_d   = cur_ang_q;
    prev_ang_d  = prev_ang_q;
    pred_d      = pred_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    dstart_d    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = {stamp_new, ang_q};
    mem_re      = 1'b0;
    mem_raddr   = slot(old_q, idx_q);
    case (st_q)
      S_IDLE: begin
        if (in_xfer) begin
          now_d = now_time_us_i;
          ang_d = steer_angle_i;
          if (!cmd_i) begin
            st_d = S_ST_WR;
          end else begin
            tcur_d   = last_t_q;
            last_t_d = now_time_us_i;
            acc_d    = '0;
            dfrom_d  = last_t_q;
            dto_d    = now_time_us_i;
            ctx_d    = CTX_PRED;
            dstart_d = 1'b1;
            st_d     = S_DEC_WAIT;
          end
        end
      end
      S_ST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = slot(old_n, cnt_n);
        mem_re    = 1'b1;
        mem_raddr = slot(old_n, CW'(1));
        stamp_d   = stamp_new;
        old_d     = old_n;
        cnt_d     = cnt_n + 1'b1;
        st_d      = (cnt_n >= CW'(2)) ? S_ST_CHK : S_IDLE;
      end
      S_ST_CHK: begin
        // drop the oldest when the new stamp runs too far past entry one
        if (stamp_q > rd_stamp &&
            (stamp_q - rd_stamp) > (STAMP_W'(dead_q) + KEEP_US)) begin
          old_d = slot(old_q, CW'(1));
          cnt_d = cnt_q - 1'b1;
        end
        st_d = S_IDLE;
      end
      S_DEC_WAIT: begin
        if (dec_done) begin
          prod_d = mul_p;
          st_d   = S_ADD;
        end
      end
      S_ADD: begin
        acc_d = acc_q + ACC_W'(prod_q);
        case (ctx_q)
          CTX_PRED: begin
            if (cnt_q > CW'(2)) begin
              idx_d = '0;
              st_d  = S_SA_RD;
            end else begin
              st_d = S_FIN;
            end
          end
          CTX_MID: begin
            tcur_d     = cur_stamp_q;
            prev_ang_d = cur_ang_q;
            idx_d      = idx_q + 1'b1;
            if ((CW+1)'(idx_q) + (CW+1)'(1) >= (CW+1)'(cnt_q)) begin
              dfrom_d  = cur_stamp_q;
              dto_d    = now_q;
              ctx_d    = CTX_LAST;
              dstart_d = 1'b1;
              st_d     = S_DEC_WAIT;
            end else begin
              st_d = S_SB_RD;
            end
          end
          default: st_d = S_FIN;
        endcase
      end
      S_SA_RD: begin
        mem_re = 1'b1;
        st_d   = S_SA_CHK;
      end
      S_SA_CHK: begin
        cur_stamp_d = rd_stamp;
        cur_ang_d   = rd_ang;
        if (idx_q == '0) begin
          prev_ang_d = rd_ang;
          idx_d      = CW'(1);
          st_d       = S_SA_RD;
        end else if (tcur_q > rd_stamp) begin
          // start lies past this stamp: skip ahead, or nothing to sum
          if ((CW+1)'(idx_q) + (CW+1)'(1) >= (CW+1)'(cnt_q)) begin
            st_d = S_FIN;
          end else begin
            prev_ang_d = rd_ang;
            idx_d      = idx_q + 1'b1;
            st_d       = S_SA_RD;
          end
        end else begin
          st_d = S_SB_EVAL;
        end
      end
      S_SB_RD: begin
        mem_re = 1'b1;
        st_d   = S_SB_CAP;
      end
      S_SB_CAP: begin
        cur_stamp_d = rd_stamp;
        cur_ang_d   = rd_ang;
        st_d        = S_SB_EVAL;
      end
      S_SB_EVAL: begin
        dfrom_d  = tcur_q;
        dstart_d = 1'b1;
        st_d     = S_DEC_WAIT;
        if (now_q > cur_stamp_q) begin
          dto_d = cur_stamp_q;
          ctx_d = CTX_MID;
        end else begin
          dto_d = now_q;
          ctx_d = CTX_LAST;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          pred_d      = rs;
          last_p_d    = rs;
          st_d        = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      ctx_q       <= CTX_PRED;
      cnt_q       <= '0;
      old_q       <= '0;
      idx_q       <= '0;
      last_t_q    <= '0;
      last_p_q    <= '0;
      dstart_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ctx_q       <= ctx_d;
      cnt_q       <= cnt_d;
      old_q       <= old_d;
      idx_q       <= idx_d;
      last_t_q    <= last_t_d;
      last_p_q    <= last_p_d;
      dstart_q    <= dstart_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    stamp_q     <= stamp_d;
    tcur_q      <= tcur_d;
    cur_stamp_q <= cur_stamp_d;
    dfrom_q     <= dfrom_d;
    dto_q       <= dto_d;
    ang_q       <= ang_d;
    cur_ang_q   <= cur_ang_d;
    prev_ang_q  <= prev_ang_d;
    pred_q      <= pred_d;
    acc_q       <= acc_d;
    prod_q      <= prod_d;
  end

  assign out_valid_o       = out_valid_q;
  assign predicted_angle_o = pred_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(BUFFER_DEPTH))
    else $error("command count exceeds ring depth");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !(out_valid_q && !out_stall_i) && $past(out_valid_q && !out_stall_i))
      |-> $past(st_q) == S_FIN)
    else $error("result raised outside final step");

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_done |-> st_q == S_DEC_WAIT)
    else $error("decay result arrived while not waiting");

  a_ring_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> cnt_q != '0)
    else $error("ring empty right after a store");

endmodule

// File: tb/testbench.sv
// Testbench for delayed_first_order_steer_predictor: random and directed store/predict
// transfers, register writes over APB between phases, checks of each predicted angle.
// Depends on dsteer_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench;
  import dsteer_pkg::*;

  localparam int DEPTH = 32;
  localparam int TBITS = 10;
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_PREDICT = 1'b1;
  localparam longint unsigned STAMP_TOP = 64'hFFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic cmd;
    logic [47:0] now;
    logic signed [15:0] angle;
  } steer_item_t;

  logic clk_i = 0, rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 0, cmd_i = 0;
  logic in_stall_o;
  logic [47:0] now_time_us_i = '0;
  logic signed [15:0] steer_angle_i = '0;
  logic out_valid_o, out_stall_i = 0;
  logic signed [15:0] predicted_angle_o;

  delayed_first_order_steer_predictor dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // predictor state
  longint unsigned tau_us, dead_us;
  longint unsigned ring_stamp[DEPTH];
  shortint ring_angle[DEPTH];
  int unsigned held, head;
  longint unsigned last_t;
  shortint last_angle;

  steer_item_t pending_items[$];
  logic signed [15:0] expected_angles[$];
  int errors = 0, n_store = 0, n_pred = 0, n_checked = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int quiet_cycles = 0;
  longint unsigned t_now = 0;

  function automatic longint unsigned exp_q24(longint unsigned a, longint unsigned b);
    longint unsigned d, tau, x, e;
    d = (b > a) ? b - a : 0;
    tau = (tau_us != 0) ? tau_us : 1;
    x = (d << TBITS) / tau;
    e = 64'd16777216;
    if ((x >> (TBITS + 4)) != 0) return 0;
    for (int j = 0; j < TBITS + 4; j++)
      if ((x >> j) & 1) e = (e * decay_factor(5'(j - TBITS + 14)) + 64'd8388608) >> 24;
    return e;
  endfunction

  function automatic longint lag_term(longint unsigned a, longint unsigned b, shortint ang);
    return longint'(64'd16777216 - exp_q24(a, b)) * longint'(ang);
  endfunction

  function automatic int unsigned ring_slot(int unsigned i);
    return (head + i) % DEPTH;
  endfunction

  function automatic longint segment_sum(longint unsigned t0, longint unsigned t1);
    int unsigned idx;
    longint unsigned t, s;
    longint acc;
    idx = 1; t = t0; acc = 0;
    while (t0 > ring_stamp[ring_slot(idx)]) begin
      if (idx + 1 >= held) return 0;
      idx++;
    end
    while (t1 > ring_stamp[ring_slot(idx)]) begin
      s = ring_stamp[ring_slot(idx)];
      acc += lag_term(t, s, ring_angle[ring_slot(idx - 1)]);
      t = s;
      idx++;
      if (idx >= held) break;
    end
    acc += lag_term(t, t1, ring_angle[ring_slot(idx - 1)]);
    return acc;
  endfunction

  function automatic void drop_oldest();
    if (held > 0) begin
      head = (head + 1) % DEPTH;
      held--;
    end
  endfunction

  function automatic void predict_step(steer_item_t it);
    longint unsigned stamp, s1;
    longint acc, r;
    if (it.cmd == CMD_STORE) begin
      stamp = it.now + dead_us;
      if (stamp > STAMP_TOP) stamp = STAMP_TOP;
      if (held >= DEPTH) drop_oldest();
      ring_stamp[ring_slot(held)] = stamp;
      ring_angle[ring_slot(held)] = it.angle;
      held++;
      if (held > 2) begin
        s1 = ring_stamp[ring_slot(1)];
        if (stamp > s1 && stamp - s1 > dead_us + 300000) drop_oldest();
      end
    end else begin
      acc = longint'(exp_q24(last_t, it.now)) * longint'(last_angle);
      if (held > 2) acc += segment_sum(last_t, it.now);
      last_t = it.now;
      if (acc >= 0) r = (acc + 64'sd8388608) >>> 24;
      else r = -((-acc + 64'sd8388608) >>> 24);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      last_angle = shortint'(r);
      expected_angles.push_back(16'(r));
    end
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_step(pending_items.pop_front());
      end
      if ((!in_valid_i || !in_stall_o) && pending_items.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1;
        cmd_i <= pending_items[0].cmd;
        now_time_us_i <= pending_items[0].now;
        steer_angle_i <= pending_items[0].angle;
      end else if (in_valid_i && !in_stall_o) begin
        in_valid_i <= 0;
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        n_checked++;
        if (expected_angles.size() == 0)
          report_mismatch($sformatf("unexpected result %0d", predicted_angle_o));
        else begin
          if (predicted_angle_o !== expected_angles[0])
            report_mismatch($sformatf("predicted_angle got %0d want %0d",
                                      predicted_angle_o, expected_angles[0]));
          void'(expected_angles.pop_front());
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", expected_angles.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= data; penable <= 0;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == REG_TAU) tau_us = data[23:0];
    else dead_us = data[19:0];
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_angles.size() > 0)
      @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
  endtask

  task automatic queue_item(logic c, longint unsigned t, logic signed [15:0] a);
    steer_item_t it;
    it.cmd = c; it.now = t[47:0]; it.angle = a;
    pending_items.push_back(it);
    if (c == CMD_STORE) n_store++; else n_pred++;
  endtask

  // mostly well-formed traffic: stores at tens of Hz with predicts between
  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: queue_item($urandom_range(1), {$urandom, $urandom} & STAMP_TOP, $urandom);
        1: queue_item($urandom_range(1), t_now - $urandom_range(50000), $urandom);
        default: begin
          t_now += $urandom_range(($urandom_range(3) == 0) ? 900000 : 60000);
          queue_item(($urandom_range(2) == 0) ? CMD_PREDICT : CMD_STORE, t_now,
                     ($urandom_range(5) == 0) ? 16'($urandom) :
                     16'($signed($urandom_range(8000)) - 4000));
        end
      endcase
    end
  endtask

  initial begin
    tau_us = 270000; dead_us = 0;
    held = 0; head = 0; last_t = 0; last_angle = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, time going backward, full ring, stale drop, stamp overflow
    send_idle_pct = 34; recv_idle_pct = 73;
    queue_item(CMD_PREDICT, 0, 0);
    queue_item(CMD_STORE, 1000, 16'sh7FFF);
    queue_item(CMD_STORE, 2000, 16'sh8000);
    queue_item(CMD_PREDICT, 3000, 0);
    queue_item(CMD_STORE, 5000, 16'sh7FFF);
    queue_item(CMD_STORE, 9000, 16'sh7FFF);
    queue_item(CMD_PREDICT, 100000, 0);
    queue_item(CMD_PREDICT, 50000, 0);
    queue_item(CMD_PREDICT, 5000000, 0);
    queue_item(CMD_STORE, 2000000, 16'sh1234);
    queue_item(CMD_PREDICT, 2100000, 0);
    for (int i = 0; i < 36; i++) begin
      t_now = 2100000 + i * 1000;
      pending_items.push_back('{CMD_STORE, t_now[47:0], 16'(i * 900 - 16000)});
    end
    queue_item(CMD_PREDICT, t_now + 500, 16'hFFFF);
    drain();
    apb_write(REG_TAU, 32'd1000);
    apb_write(REG_DEAD, 32'd1000000);
    queue_item(CMD_STORE, STAMP_TOP - 10, 16'sh7FFF);
    queue_item(CMD_STORE, STAMP_TOP, 16'sh8000);
    queue_item(CMD_PREDICT, STAMP_TOP, 16'sh5555);
    queue_item(CMD_PREDICT, 48'hAAAA_AAAA_AAAA, 16'shAAAA);
    drain();
    apb_write(REG_TAU, 32'd0);
    apb_write(REG_DEAD, 32'd0);
    t_now = 64'h0000_8000_0000_0000 >> 16;
    random_phase(60);
    drain();

    send_idle_pct = 73; recv_idle_pct = 34;
    apb_write(REG_TAU, 32'd10000000);
    apb_write(REG_DEAD, 32'd45000);
    random_phase(120);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    apb_write(REG_TAU, 32'hFFFFFF);
    apb_write(REG_DEAD, 32'hFFFFF);
    random_phase(60);
    drain();
    apb_write(REG_TAU, 32'd270000);
    apb_write(REG_DEAD, 32'd150000);
    random_phase(60);
    drain();

    $display("ran %0d stores and %0d predicts, %0d results checked, %0d mismatches",
             n_store, n_pred, n_checked, errors);
    if (errors == 0 && expected_angles.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
